>>> sv/pcm_sample_to_float_converter_assert.svh
// Assertion macros for the PCM sample converter
`ifndef PCM_SAMPLE_TO_FLOAT_CONVERTER_ASSERT_SVH
`define PCM_SAMPLE_TO_FLOAT_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/pcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcm_pkg;
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S24 = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    // Stage 1 -> stage 2: sign and magnitude of the fixed-point sample
    typedef struct packed {
        logic        pass;     // float word, pass through
        logic [31:0] raw;
        logic        sign;
        logic [23:0] mag;      // magnitude, Q1.23 scaled (1.0 = 2^23)
    } t_s1;

    // Stage 2 -> stage 3: normalized magnitude
    typedef struct packed {
        logic        pass;
        logic [31:0] raw;
        logic        sign;
        logic        zero;
        logic [4:0]  lz;
        logic [23:0] norm;
    } t_s2;
endpackage
`default_nettype wire

>>> sv/pcm_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One pipeline register slot with valid/ready; holds when downstream stalls.
module pcm_stage import pcm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_data
);
    logic        r_valid;
    logic [63:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end
endmodule
`default_nettype wire

>>> sv/pcm_sample_to_float_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Signals                                   Direction
// input     i_valid / o_ready / i_sample_bytes        in
// result    o_valid / i_ready / o_float_bits, o_not_finite  out
// config    i_cfg_we / i_cfg_wdata                    in
//
// Three register stages: decode to sign-magnitude, leading-zero normalize,
// pack exponent/mantissa. One item per clock while the result is not stalled.
// Synchronous active-low reset clears valid bits; format resets to signed 16.
// Each stage holds its item while the next is full and stalled, so a stall
// loses and repeats nothing.
`include "pcm_sample_to_float_converter_assert.svh"
module pcm_sample_to_float_converter import pcm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_sample_bytes,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_float_bits,
    output logic             o_not_finite
);
    logic [1:0] r_fmt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_S16;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // Stage 1: decode format into sign and magnitude scaled to 2^23; a float word is marked to pass through
    t_s1 n_s1;
    always_comb begin
        n_s1      = '0;
        n_s1.raw  = i_sample_bytes;
        case (r_fmt)
            FMT_U8: begin
                n_s1.sign = !i_sample_bytes[7];
                n_s1.mag  = i_sample_bytes[7] ? {1'b0, i_sample_bytes[6:0], 16'd0}
                          : {1'b0, 7'd0 - i_sample_bytes[6:0], 16'd0}
                            | {(i_sample_bytes[6:0] == 7'd0), 23'd0};
            end
            FMT_S16: begin
                n_s1.sign = i_sample_bytes[15];
                n_s1.mag  = i_sample_bytes[15]
                          ? {16'd0 - i_sample_bytes[15:0], 8'd0}
                          : {i_sample_bytes[15:0], 8'd0};
            end
            FMT_S24: begin
                n_s1.sign = i_sample_bytes[23];
                n_s1.mag  = i_sample_bytes[23] ? 24'd0 - i_sample_bytes[23:0]
                          : i_sample_bytes[23:0];
            end
            default: begin
                n_s1.pass = 1'b1;
            end
        endcase
    end

    logic        s1_v, s1_r, s2_v, s2_r, s3_v;
    logic [63:0] s1_q, s2_q, s3_q;
    t_s1 s1;
    t_s2 n_s2, s2;
    assign s1 = t_s1'(s1_q[57:0]);
    assign s2 = t_s2'(s2_q[63:0]);

    pcm_stage u_s1 (.i_clk, .i_rst_n, .i_valid(i_valid), .o_ready(o_ready),
        .i_data({6'd0, n_s1}), .o_valid(s1_v), .i_ready(s1_r), .o_data(s1_q));

    // Stage 2: leading-zero count and normalize
    always_comb begin
        n_s2      = '0;
        n_s2.pass = s1.pass;
        n_s2.raw  = s1.raw;
        n_s2.sign = s1.sign;
        n_s2.zero = (s1.mag == 24'd0);
        for (int k = 0; k < 24; k++) begin
            if (s1.mag[k]) n_s2.lz = 5'(23 - k);
        end
        n_s2.norm = s1.mag << n_s2.lz;
    end

    pcm_stage u_s2 (.i_clk, .i_rst_n, .i_valid(s1_v), .o_ready(s1_r),
        .i_data(n_s2), .o_valid(s2_v), .i_ready(s2_r), .o_data(s2_q));

    // Stage 3: pack; magnitude 2^23 is 1.0, so exponent is 127 - lz
    logic [63:0] n_s3;
    logic [7:0]  exp_v;
    always_comb begin
        exp_v = 8'd127 - {3'd0, s2.lz};
        n_s3  = '0;
        if (s2.pass) begin
            n_s3[31:0] = s2.raw;
            n_s3[32]   = (s2.raw[30:23] == 8'hFF);
        end else if (!s2.zero) begin
            n_s3[31:0] = {s2.sign, exp_v, s2.norm[22:0]};
        end
    end

    pcm_stage u_s3 (.i_clk, .i_rst_n, .i_valid(s2_v), .o_ready(s2_r),
        .i_data(n_s3), .o_valid(s3_v), .i_ready(i_ready), .o_data(s3_q));

    assign o_valid      = s3_v;
    assign o_float_bits = s3_q[31:0];
    assign o_not_finite = s3_q[32];

    `PCM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(s3_q), "result changed while stalled")
    `PCM_ASSERT_IMPL(a_flag, i_clk, i_rst_n, o_valid && o_not_finite |-> o_float_bits[30:23] == 8'hFF, "flag without all-ones exponent")
    `PCM_ASSERT_NEXT(a_fill, i_clk, i_rst_n, s2_v && s2_r, o_valid, "stage 3 lost an item")
endmodule
`default_nettype wire
